FILE: rtl/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
// Used by lkvc_ctrl, lkvc_datapath and lru_key_value_cache_core; no dependencies.
package lkvc_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RANK_W  = IDX_W;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int CAP_W   = 5;
   localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int DATA_W  = 32;

   localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
   localparam logic [DATA_W-1:0] MISS_VALUE = '1;

   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   typedef struct packed {
      logic                     func;
      logic signed [DATA_W-1:0] key;
      logic signed [DATA_W-1:0] write_value;
   } req_type;

   typedef struct packed {
      logic                     found;
      logic signed [DATA_W-1:0] read_value;
      logic                     evicted;
   } rsp_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

endpackage

FILE: rtl/lkvc_ctrl.sv
// Control state machine of the LRU key-value cache: handshakes and sequencing.
// Depends on lkvc_pkg.
module lkvc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lkvc_pkg::cmd_type cmd
);
   import lkvc_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // The update runs only once the result register has room.
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.exec     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   a_exec_only_in_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> state_ff == ST_EXEC)
      else $error("execute outside the execute state");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !cmd.exec)
      else $error("result register overwritten while stalled");

   a_load_then_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_EXEC)
      else $error("loaded item not held for execution");

endmodule

FILE: rtl/lkvc_datapath.sv
// Datapath of the LRU key-value cache: entry store, parallel lookup, rank update.
// Depends on lkvc_pkg.
module lkvc_datapath (
   input  logic              clock,
   input  logic              reset,
   input  lkvc_pkg::cmd_type cmd,
   input  lkvc_pkg::req_type req_data,
   input  logic              csr_write_enable,
   input  logic [lkvc_pkg::CAP_W-1:0] csr_write_data,
   output lkvc_pkg::rsp_type rsp_data
);
   import lkvc_pkg::*;

   req_type               req_ff;
   rsp_type               rsp_ff, rsp_in;
   logic [DATA_W-1:0]     key_ff [ENTRIES];
   logic [DATA_W-1:0]     value_ff [ENTRIES];
   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic [RANK_W-1:0]     rank_ff [ENTRIES];
   logic [RANK_W-1:0]     rank_in [ENTRIES];
   logic [CNT_W-1:0]      fill_ff, fill_in;
   logic [CAP_W-1:0]      cap_ff;

   logic                  hit, have_free, full;
   logic                  do_evict, do_insert, do_update;
   logic [IDX_W-1:0]      hit_idx, free_idx, victim_idx, target;
   logic [CNT_W-1:0]      old_rank, last_rank;
   logic [CMP_W-1:0]      cap_ext, cap_eff;

   always_comb begin
      cap_ext = CMP_W'(cap_ff);
      if (cap_ext == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_ext > CMP_W'(ENTRIES)) begin
         cap_eff = CMP_W'(ENTRIES);
      end else begin
         cap_eff = cap_ext;
      end
      full      = CMP_W'(fill_ff) >= cap_eff;
      last_rank = fill_ff - CNT_W'(1);
   end

   // Parallel compare of every entry; valid keys are distinct, the lowest match wins.
   always_comb begin
      hit        = 1'b0;
      hit_idx    = '0;
      have_free  = 1'b0;
      free_idx   = '0;
      victim_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && key_ff[i] == req_ff.key) begin
            hit     = 1'b1;
            hit_idx = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            have_free = 1'b1;
            free_idx  = IDX_W'(i);
         end
         // Valid ranks are exactly 0 .. fill-1, so the oldest holds fill-1.
         if (valid_ff[i] && CNT_W'(rank_ff[i]) == last_rank) begin
            victim_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      do_evict  = (req_ff.func == FUNC_WRITE) && !hit && full;
      do_insert = (req_ff.func == FUNC_WRITE) && !hit && !full && have_free;
      do_update = hit || do_evict || do_insert;

      if (hit) begin
         target   = hit_idx;
         old_rank = CNT_W'(rank_ff[hit_idx]);
      end else if (do_evict) begin
         target   = victim_idx;
         old_rank = last_rank;
      end else begin
         target   = free_idx;
         old_rank = fill_ff;
      end

      valid_in = valid_ff;
      fill_in  = fill_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
         if (do_update) begin
            if (IDX_W'(i) == target) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && CNT_W'(rank_ff[i]) < old_rank) begin
               rank_in[i] = RANK_W'(rank_ff[i] + 1'b1);
            end
         end
      end
      if (do_insert) begin
         valid_in[target] = 1'b1;
         fill_in          = fill_ff + CNT_W'(1);
      end

      rsp_in.found   = hit;
      rsp_in.evicted = do_evict;
      if (req_ff.func == FUNC_WRITE) begin
         rsp_in.read_value = req_ff.write_value;
      end else if (hit) begin
         rsp_in.read_value = value_ff[hit_idx];
      end else begin
         rsp_in.read_value = MISS_VALUE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         fill_ff  <= '0;
         cap_ff   <= CAP_RESET;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            cap_ff <= csr_write_data;
         end
         if (cmd.exec) begin
            valid_ff <= valid_in;
            fill_ff  <= fill_in;
            for (int i = 0; i < ENTRIES; i++) begin
               rank_ff[i] <= rank_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
         if (req_ff.func == FUNC_WRITE && do_update) begin
            value_ff[target] <= req_ff.write_value;
            key_ff[target]   <= req_ff.key;
         end
      end
   end

   assign rsp_data = rsp_ff;

   a_fill_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(fill_ff))
      else $error("fill count disagrees with valid entries");

   a_evict_keeps_fill: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && do_evict) |=> fill_ff == $past(fill_ff))
      else $error("eviction changed the fill count");

   a_target_most_recent: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && do_update) |=> rank_ff[$past(target)] == '0)
      else $error("touched entry not made most recent");

endmodule

FILE: rtl/lru_key_value_cache_core.sv
// Fully associative key-value cache with least-recently-used replacement.
// An item is taken in the idle state and looked up and applied in the execute
// state, where all entries are compared in parallel and all recency ranks are
// updated together; execution waits while an earlier result is stalled in the
// output register. The next item is taken while a finished result waits. The user
// must write capacity through the csr port only while idle; the block does not
// enforce it. Zero acts as one, and values above the entry count act as that count.
// Depends on lkvc_pkg, lkvc_ctrl and lkvc_datapath.
module lru_key_value_cache_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  lkvc_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output lkvc_pkg::rsp_type          rsp_data,
   input  logic                       csr_write_enable,
   input  logic [lkvc_pkg::CAP_W-1:0] csr_write_data
);
   import lkvc_pkg::*;

   cmd_type cmd;

   lkvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   lkvc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_data         (rsp_data)
   );

endmodule
